[src/assert_macros.svh]
// concurrent assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif

`endif

[src/rvp_pkg.sv]
package rvp_pkg;

   localparam int MAX_DIM_DEF = 4096;

   localparam int COORD_W   = 12;
   localparam int PIX_W     = 32;
   localparam int CFG_W     = 13;
   localparam int LEVEL_W   = 3;
   localparam int ATT_W     = 8;
   localparam int Q_W       = 8;
   localparam int CSR_IDX_W = 2;
   localparam int SCALE_ONE = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEVEL        = 2'd2;

   localparam logic [CFG_W-1:0]   WIDTH_RST  = 13'd320;
   localparam logic [CFG_W-1:0]   HEIGHT_RST = 13'd200;
   localparam logic [LEVEL_W-1:0] LEVEL_RST  = 3'd0;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [ATT_W-1:0] att_max;
   } side_type;

   // attenuation table, levels of four and above saturate
   function automatic logic [ATT_W-1:0] att_lookup(input logic [LEVEL_W-1:0] level);
      logic [ATT_W-1:0] att;
      unique case (level)
         3'd0: att = 8'd0;
         3'd1: att = 8'd80;
         3'd2: att = 8'd146;
         3'd3: att = 8'd200;
         default: att = 8'd255;
      endcase
      return att;
   endfunction

endpackage

[src/radial_vignette_pixel_top.sv]
// Radial vignette, one ARGB pixel per clock. Pulse start with req_pixel_x,
// req_pixel_y and req_pixel_in while busy is low; busy is high only around
// reset. Every request gives exactly one response, through four
// distance stages (offsets, squares, sum, numerator), eight divider stages
// that each resolve one bit of the attenuation quotient, and one scaling
// stage that drives the output register. rsp_valid is high for a single
// cycle with rsp_pixel_out; there is no way to hold a response, so the
// receiver must take it then. Write the csr registers only with no request
// in flight; after a write the corner settles via the square and corner registers.
module radial_vignette_pixel_top #(
   parameter int MAX_DIM = rvp_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [rvp_pkg::COORD_W-1:0]     req_pixel_x,
   input  logic [rvp_pkg::COORD_W-1:0]     req_pixel_y,
   input  logic [rvp_pkg::PIX_W-1:0]       req_pixel_in,
   output logic                            rsp_valid,
   output logic [rvp_pkg::PIX_W-1:0]       rsp_pixel_out,
   input  logic                            csr_we,
   input  logic [rvp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rvp_pkg::CFG_W-1:0]       csr_wdata
);
   import rvp_pkg::*;

   localparam int DIM_W    = $clog2(MAX_DIM+1);
   localparam int CX_W     = DIM_W - 1;
   localparam int D_W      = (CX_W > COORD_W) ? CX_W : COORD_W;
   localparam int CORNER_W = 2*CX_W + 1;
   localparam int NUM_W    = 2*D_W + 1 + ATT_W;

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic               busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         level_ff  <= LEVEL_RST;
         busy_ff   <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               CSR_LEVEL:        level_ff  <= csr_wdata[LEVEL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign busy = busy_ff;

   logic     req_accept;
   side_type req_side;

   assign req_accept       = start && !busy_ff;
   assign req_side.pixel   = req_pixel_in;
   assign req_side.att_max = att_lookup(level_ff);

   logic [CORNER_W-1:0] corner;
   logic                dist_valid, dist_sat;
   logic [NUM_W-1:0]    dist_num;
   side_type            dist_side;

   rvp_dist #(
      .MAX_DIM (MAX_DIM)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .width_cfg  (width_ff),
      .height_cfg (height_ff),
      .in_valid   (req_accept),
      .in_x       (req_pixel_x),
      .in_y       (req_pixel_y),
      .in_side    (req_side),
      .corner     (corner),
      .out_valid  (dist_valid),
      .out_num    (dist_num),
      .out_sat    (dist_sat),
      .out_side   (dist_side)
   );

   logic           div_valid, div_sat;
   logic [Q_W-1:0] div_q;
   side_type       div_side;

   rvp_div #(
      .MAX_DIM (MAX_DIM)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .corner    (corner),
      .in_valid  (dist_valid),
      .in_num    (dist_num),
      .in_sat    (dist_sat),
      .in_side   (dist_side),
      .out_valid (div_valid),
      .out_q     (div_q),
      .out_sat   (div_sat),
      .out_side  (div_side)
   );

   rvp_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_q      (div_q),
      .in_sat    (div_sat),
      .in_side   (div_side),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out)
   );

endmodule

[src/rvp_dist.sv]
module rvp_dist #(
   parameter int MAX_DIM = rvp_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rvp_pkg::CFG_W-1:0]           width_cfg,
   input  logic [rvp_pkg::CFG_W-1:0]           height_cfg,
   input  logic                                in_valid,
   input  logic [rvp_pkg::COORD_W-1:0]         in_x,
   input  logic [rvp_pkg::COORD_W-1:0]         in_y,
   input  rvp_pkg::side_type                   in_side,
   output logic [2*($clog2(MAX_DIM+1)-1):0]    corner,
   output logic                                out_valid,
   output logic [2*(($clog2(MAX_DIM+1)-1 > rvp_pkg::COORD_W) ?
                   ($clog2(MAX_DIM+1)-1) : rvp_pkg::COORD_W) + rvp_pkg::ATT_W:0] out_num,
   output logic                                out_sat,
   output rvp_pkg::side_type                   out_side
);
   import rvp_pkg::*;

   localparam int DIM_W    = $clog2(MAX_DIM+1);
   localparam int CX_W     = DIM_W - 1;
   localparam int D_W      = (CX_W > COORD_W) ? CX_W : COORD_W;
   localparam int DIST_W   = 2*D_W + 1;
   localparam int CORNER_W = 2*CX_W + 1;
   localparam int NUM_W    = DIST_W + ATT_W;

   logic [CX_W-1:0] cx, cy;

   // center from clamped frame size
   assign cx = (32'(width_cfg) > 32'(MAX_DIM)) ? CX_W'(MAX_DIM/2) : CX_W'(width_cfg >> 1);
   assign cy = (32'(height_cfg) > 32'(MAX_DIM)) ? CX_W'(MAX_DIM/2) : CX_W'(height_cfg >> 1);

   // corner distance, two register stages off the config
   logic [2*CX_W-1:0]   cxsq_ff, cysq_ff;
   logic [CORNER_W-1:0] corner_ff;

   always_ff @(posedge clock) begin
      cxsq_ff   <= {{CX_W{1'b0}}, cx} * {{CX_W{1'b0}}, cx};
      cysq_ff   <= {{CX_W{1'b0}}, cy} * {{CX_W{1'b0}}, cy};
      corner_ff <= CORNER_W'(cxsq_ff) + CORNER_W'(cysq_ff);
   end

   assign corner = corner_ff;

   // stage a: absolute offsets
   logic [D_W-1:0] x_ext, y_ext, cx_ext, cy_ext, dx_in, dy_in;
   assign x_ext  = D_W'(in_x);
   assign y_ext  = D_W'(in_y);
   assign cx_ext = D_W'(cx);
   assign cy_ext = D_W'(cy);
   assign dx_in  = (x_ext >= cx_ext) ? x_ext - cx_ext : cx_ext - x_ext;
   assign dy_in  = (y_ext >= cy_ext) ? y_ext - cy_ext : cy_ext - y_ext;

   logic           a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [D_W-1:0] dx_ff, dy_ff;
   side_type       a_side_ff, b_side_ff, c_side_ff, d_side_ff;

   // stage b: squares
   logic [2*D_W-1:0] dxsq_ff, dysq_ff;
   // stage c: squared distance
   logic [DIST_W-1:0] dist2_ff;
   // stage d: numerator and saturation flag
   logic [NUM_W-1:0] num_ff;
   logic             sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      a_side_ff <= in_side;
      dxsq_ff   <= {{D_W{1'b0}}, dx_ff} * {{D_W{1'b0}}, dx_ff};
      dysq_ff   <= {{D_W{1'b0}}, dy_ff} * {{D_W{1'b0}}, dy_ff};
      b_side_ff <= a_side_ff;
      dist2_ff  <= DIST_W'(dxsq_ff) + DIST_W'(dysq_ff);
      c_side_ff <= b_side_ff;
      num_ff    <= NUM_W'(dist2_ff) * NUM_W'(c_side_ff.att_max);
      sat_ff    <= dist2_ff >= DIST_W'(corner_ff);
      d_side_ff <= c_side_ff;
   end

   assign out_valid = d_valid_ff;
   assign out_num   = num_ff;
   assign out_sat   = sat_ff;
   assign out_side  = d_side_ff;

endmodule

[src/rvp_div.sv]
`include "assert_macros.svh"

module rvp_div #(
   parameter int MAX_DIM = rvp_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [2*($clog2(MAX_DIM+1)-1):0]    corner,
   input  logic                                in_valid,
   input  logic [2*(($clog2(MAX_DIM+1)-1 > rvp_pkg::COORD_W) ?
                  ($clog2(MAX_DIM+1)-1) : rvp_pkg::COORD_W) + rvp_pkg::ATT_W:0] in_num,
   input  logic                                in_sat,
   input  rvp_pkg::side_type                   in_side,
   output logic                                out_valid,
   output logic [rvp_pkg::Q_W-1:0]             out_q,
   output logic                                out_sat,
   output rvp_pkg::side_type                   out_side
);
   import rvp_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM+1);
   localparam int CX_W   = DIM_W - 1;
   localparam int D_W    = (CX_W > COORD_W) ? CX_W : COORD_W;
   localparam int NUM_W  = 2*D_W + 1 + ATT_W;

   // restoring division, one quotient bit per stage, msb first
   logic [Q_W-1:0]   vld_ff;
   logic [Q_W-1:0]   sat_ff;
   logic [Q_W-1:0]   q_ff   [Q_W];
   side_type         side_ff[Q_W];
   logic [NUM_W-1:0] rem_ff [Q_W-1];

   for (genvar s = 0; s < Q_W; s++) begin : g_stage
      logic [NUM_W-1:0] rem_prev, dvs;
      logic [Q_W-1:0]   q_prev, q_in;
      logic             v_prev, s_prev, fits;
      side_type         side_prev;

      if (s == 0) begin : g_first
         assign rem_prev  = in_num;
         assign q_prev    = '0;
         assign v_prev    = in_valid;
         assign s_prev    = in_sat;
         assign side_prev = in_side;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign q_prev    = q_ff[s-1];
         assign v_prev    = vld_ff[s-1];
         assign s_prev    = sat_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      assign dvs  = NUM_W'(corner) << (Q_W-1-s);
      assign fits = rem_prev >= dvs;

      always_comb begin
         q_in = q_prev;
         q_in[Q_W-1-s] = fits;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         q_ff[s]    <= q_in;
         sat_ff[s]  <= s_prev;
         side_ff[s] <= side_prev;
      end

      if (s < Q_W-1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[s] <= fits ? rem_prev - dvs : rem_prev;
         end
      end
   end

   assign out_valid = vld_ff[Q_W-1];
   assign out_q     = q_ff[Q_W-1];
   assign out_sat   = sat_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

   // below the corner the quotient stays under the table value
   `ASSERT_IMPLIES(a_q_below_max, clock, reset, out_valid && !out_sat && out_side.att_max != '0, out_q < out_side.att_max)
   `ASSERT_PROP(a_div_latency, clock, reset, in_valid |-> ##Q_W out_valid)
   `ASSERT_PROP(a_div_no_phantom, clock, reset, !in_valid |-> ##Q_W !out_valid)

endmodule

[src/rvp_scale.sv]
`include "assert_macros.svh"

module rvp_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [rvp_pkg::Q_W-1:0]      in_q,
   input  logic                         in_sat,
   input  rvp_pkg::side_type            in_side,
   output logic                         out_valid,
   output logic [rvp_pkg::PIX_W-1:0]    out_pixel
);
   import rvp_pkg::*;

   logic [ATT_W-1:0]  atten;
   logic [ATT_W:0]    scale;
   logic [ATT_W+8:0]  r_prod, g_prod, b_prod;
   logic [PIX_W-1:0]  pixel_in;

   assign atten  = in_sat ? in_side.att_max : ATT_W'(in_q);
   assign scale  = (ATT_W+1)'(SCALE_ONE) - {1'b0, atten};
   assign r_prod = {9'd0, in_side.pixel[23:16]} * {8'd0, scale};
   assign g_prod = {9'd0, in_side.pixel[15:8]}  * {8'd0, scale};
   assign b_prod = {9'd0, in_side.pixel[7:0]}   * {8'd0, scale};

   // level zero passes the pixel through untouched, alpha included
   assign pixel_in = (in_side.att_max == '0) ? in_side.pixel :
                     {ALPHA_OPAQUE, r_prod[15:8], g_prod[15:8], b_prod[15:8]};

   logic             valid_ff;
   logic [PIX_W-1:0] pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

   `ASSERT_PROP(a_scale_follow, clock, reset, in_valid |=> out_valid)
   `ASSERT_PROP(a_scale_alpha, clock, reset, (in_valid && in_side.att_max != '0) |=> out_pixel[31:24] == ALPHA_OPAQUE)

endmodule
